/* sv/bpq_pkg.sv */
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and codes of the bucketed priority queue: request and result
// payloads, the entry held by one cell, and the per-cycle command to the row.
// ----------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

    localparam int ELEM_WIDTH   = 32;
    localparam int LEVEL_WIDTH  = 4;
    localparam int COUNT_WIDTH  = 7;
    localparam int ACTION_WIDTH = 2;
    localparam int STATUS_WIDTH = 2;

    // action codes; the unused code behaves as a query
    localparam logic [ACTION_WIDTH-1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [ACTION_WIDTH-1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [ACTION_WIDTH-1:0] ACT_QUERY   = 2'd2;

    // status codes
    localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_LEVEL = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [ACTION_WIDTH-1:0] action;
        logic [ELEM_WIDTH-1:0]   elem_value;
        logic [LEVEL_WIDTH-1:0]  level;
    } bpq_in_t;

    typedef struct packed {
        logic [ELEM_WIDTH-1:0]   removed_value;
        logic [ELEM_WIDTH-1:0]   front_value;
        logic [LEVEL_WIDTH-1:0]  front_level;
        logic [COUNT_WIDTH-1:0]  count;
        logic                    is_empty;
        logic [STATUS_WIDTH-1:0] status;
    } bpq_out_t;

    // one stored element as held by a cell
    typedef struct packed {
        logic                   valid;
        logic [LEVEL_WIDTH-1:0] level;
        logic [ELEM_WIDTH-1:0]  value;
    } bpq_entry_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic                   enq;
        logic                   deq;
        logic [LEVEL_WIDTH-1:0] level;
        logic [ELEM_WIDTH-1:0]  value;
    } bpq_op_t;

endpackage

`default_nettype wire

/* sv/bpq_cell.sv */
// ----------------------------------------------------------------------------
// bpq_cell
// One slot of the sorted row. Holds one entry; on enqueue it keeps its entry,
// takes the new one or takes its left neighbor's; on dequeue it takes its
// right neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_cell (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire bpq_pkg::bpq_op_t    op,
    input  wire bpq_pkg::bpq_entry_t left_ent,
    input  wire logic                left_stay,
    input  wire bpq_pkg::bpq_entry_t right_ent,
    output bpq_pkg::bpq_entry_t      ent,
    output logic                     stay
);
    import bpq_pkg::*;

    bpq_entry_t ent_reg;
    bpq_entry_t ent_next;

    // entries at or above the new level in urgency keep their place (FIFO per level)
    assign stay = ent_reg.valid && (ent_reg.level <= op.level);
    assign ent  = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (op.deq) begin
            ent_next = right_ent;
        end else if (op.enq && !stay) begin
            if (left_stay) begin
                ent_next.valid = 1'b1;
                ent_next.level = op.level;
                ent_next.value = op.value;
            end else begin
                ent_next = left_ent;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_reg.valid <= 1'b0;
        end else begin
            ent_reg <= ent_next;
        end
    end

endmodule

`default_nettype wire

/* sv/bpq_chain.sv */
// ----------------------------------------------------------------------------
// bpq_chain
// Row of cells kept sorted by level, oldest first within a level. Cell 0 is
// the front of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_chain #(
    parameter int CAPACITY = 64
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bpq_pkg::bpq_op_t op,
    output bpq_pkg::bpq_entry_t   head
);
    import bpq_pkg::*;

    bpq_entry_t ent  [CAPACITY];
    logic       stay [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        bpq_entry_t left_ent;
        logic       left_stay;
        bpq_entry_t right_ent;

        if (i == 0) begin : g_first
            assign left_ent  = '0;
            assign left_stay = 1'b1;
        end else begin : g_mid
            assign left_ent  = ent[i-1];
            assign left_stay = stay[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_ent = '0;
        end else begin : g_inner
            assign right_ent = ent[i+1];
        end

        bpq_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op        (op),
            .left_ent  (left_ent),
            .left_stay (left_stay),
            .right_ent (right_ent),
            .ent       (ent[i]),
            .stay      (stay[i])
        );
    end

    assign head = ent[0];

endmodule

`default_nettype wire

/* sv/bucketed_priority_fifo_queue.sv */
// ----------------------------------------------------------------------------
// bucketed_priority_fifo_queue
// Priority queue with FIFO order inside each level, built as a sorted row of
// cells.
// ----------------------------------------------------------------------------
// A request is accepted in S_IDLE: at the accepting edge the whole cell row
// shifts or inserts in one step and the element count updates. In S_SETTLE
// the result register loads the front from cell 0 once the output register
// frees; no new request is taken until the state is back in S_IDLE. While a
// finished result waits on m_ready, one more request is taken and its result
// holds in S_SETTLE until the output register frees. Storage is CAPACITY
// cells of one element each; no clearing pass is needed after reset.
// max_priority is written through cfg_wr_en/cfg_wr_data and resets to 15.
`default_nettype none

module bucketed_priority_fifo_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire bpq_pkg::bpq_in_t                     s_data,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output bpq_pkg::bpq_out_t                         m_data,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [bpq_pkg::LEVEL_WIDTH-1:0]      cfg_wr_data
);
    import bpq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SETTLE = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic [LEVEL_WIDTH-1:0]  max_prio_reg;
    logic [CW-1:0]           count_reg, count_next;
    logic [STATUS_WIDTH-1:0] status_reg, status_next;
    logic [ELEM_WIDTH-1:0]   removed_reg, removed_next;
    logic                    m_valid_reg, m_valid_next;
    bpq_out_t                m_data_reg, m_data_next;

    bpq_op_t    op;
    bpq_entry_t head;
    logic       accept;
    logic       full;
    logic       enq_ok;
    logic       deq_ok;
    logic       out_free;

    assign accept   = s_valid && s_ready;
    assign full     = (count_reg == CW'(CAPACITY));
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        enq_ok      = 1'b0;
        deq_ok      = 1'b0;
        status_next = ST_OK;
        unique case (s_data.action)
            ACT_ENQUEUE: begin
                if (s_data.level > max_prio_reg) begin
                    status_next = ST_BAD_LEVEL;
                end else if (full) begin
                    status_next = ST_FULL;
                end else begin
                    enq_ok = 1'b1;
                end
            end
            ACT_DEQUEUE: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    deq_ok = 1'b1;
                end
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb begin
        op.enq   = accept && enq_ok;
        op.deq   = accept && deq_ok;
        op.level = s_data.level;
        op.value = s_data.elem_value;
    end

    bpq_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (op),
        .head    (head)
    );

    always_comb begin
        removed_next = deq_ok ? head.value : '0;
        count_next   = count_reg;
        if (op.enq) begin
            count_next = count_reg + CW'(1);
        end else if (op.deq) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        m_data_next.removed_value = removed_reg;
        m_data_next.front_value   = head.valid ? head.value : '0;
        m_data_next.front_level   = head.valid ? head.level : '0;
        m_data_next.count         = COUNT_WIDTH'(count_reg);
        m_data_next.is_empty      = (count_reg == '0);
        m_data_next.status        = status_reg;
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE: begin
                // hold here until the output register frees
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            max_prio_reg <= {LEVEL_WIDTH{1'b1}};
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            if (cfg_wr_en) begin
                max_prio_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
        if (state_reg == S_SETTLE && out_free) begin
            m_data_reg <= m_data_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* sv/bpq_checker.sv */
// ----------------------------------------------------------------------------
// bpq_checker
// Port-level checks of the bucketed priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire bpq_pkg::bpq_out_t               m_data
);
    import bpq_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one request at a time: ready drops right after an accept
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous one in flight");

    // an empty queue reports a zero front and a zero count
    a_empty_front: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_empty |->
            m_data.front_value == '0 && m_data.front_level == '0 && m_data.count == '0)
        else $error("empty result with nonzero front or count");

    // a refused dequeue removes nothing and leaves the queue empty
    a_empty_deq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_EMPTY |->
            m_data.removed_value == '0 && m_data.is_empty)
        else $error("empty dequeue reported a removed element");

endmodule

bind bucketed_priority_fifo_queue bpq_checker u_bpq_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bucketed_priority_fifo_queue. A short table of
// requests walks the empty, bad-level and lowered-maximum cases. Random phases
// follow that fill the queue to full and drain it back to empty under changing
// max_priority settings. Both handshakes see random gaps. A result is compared
// with a table row's result if given, else a behavioral per-level FIFO model.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpq_pkg::*;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_LEVEL   = (1 << LEVEL_WIDTH) - 1;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 100;
    localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] lvl;
        logic [ELEM_WIDTH-1:0]  val;
    } held_elem_t;

    typedef struct packed {
        logic                   is_cfg;
        logic                   typed;
        logic [LEVEL_WIDTH-1:0] cfg_val;
        bpq_in_t                req;
        bpq_out_t               result;
    } step_row_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   s_valid     = 1'b0;
    logic                   s_ready;
    bpq_in_t                s_data      = '0;
    logic                   m_valid;
    logic                   m_ready     = 1'b0;
    bpq_out_t               m_data;
    logic                   cfg_wr_en   = 1'b0;
    logic [LEVEL_WIDTH-1:0] cfg_wr_data = '0;

    // model state: elements in arrival order, plus the current maximum level
    held_elem_t             held[$];
    logic [LEVEL_WIDTH-1:0] max_level_cfg = MAX_LEVEL;
    bpq_out_t               pending_results[$];
    step_row_t              dir_rows[$];
    int                     mismatch_count = 0;
    int                     rx_stall = 0;
    bit                     tx_idle_en = 1'b1;
    bit                     rx_idle_en = 1'b1;

    bucketed_priority_fifo_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // oldest element of the lowest level present, or -1 when empty
    function automatic int front_index();
        int best;
        best = -1;
        foreach (held[k]) begin
            if (best < 0 || held[k].lvl < held[best].lvl) begin
                best = k;
            end
        end
        return best;
    endfunction

    function automatic bpq_out_t predict_step(bpq_in_t r);
        bpq_out_t   o;
        held_elem_t e;
        int         idx;
        o = '0;
        o.status = ST_OK;
        case (r.action)
            ACT_ENQUEUE: begin
                if (r.level > max_level_cfg) begin
                    o.status = ST_BAD_LEVEL;
                end else if (held.size() >= QUEUE_DEPTH) begin
                    o.status = ST_FULL;
                end else begin
                    e.lvl = r.level;
                    e.val = r.elem_value;
                    held.push_back(e);
                end
            end
            ACT_DEQUEUE: begin
                idx = front_index();
                if (idx < 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    o.removed_value = held[idx].val;
                    held.delete(idx);
                end
            end
            default: ;  // query and the unused code change nothing
        endcase
        idx = front_index();
        if (idx >= 0) begin
            o.front_value = held[idx].val;
            o.front_level = held[idx].lvl;
        end
        o.count    = COUNT_WIDTH'(held.size());
        o.is_empty = (held.size() == 0);
        return o;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic bpq_out_t result_of(logic [ELEM_WIDTH-1:0] removed,
                                           logic [ELEM_WIDTH-1:0] front,
                                           logic [LEVEL_WIDTH-1:0] front_lvl,
                                           int cnt, logic [STATUS_WIDTH-1:0] st);
        bpq_out_t o;
        o.removed_value = removed;
        o.front_value   = front;
        o.front_level   = front_lvl;
        o.count         = COUNT_WIDTH'(cnt);
        o.is_empty      = (cnt == 0);
        o.status        = st;
        return o;
    endfunction

    function automatic step_row_t req_row(logic [ACTION_WIDTH-1:0] act,
                                          logic [ELEM_WIDTH-1:0] val,
                                          logic [LEVEL_WIDTH-1:0] lvl);
        step_row_t row;
        row                = '0;
        row.req.action     = act;
        row.req.elem_value = val;
        row.req.level      = lvl;
        return row;
    endfunction

    function automatic step_row_t chk_row(logic [ACTION_WIDTH-1:0] act,
                                          logic [ELEM_WIDTH-1:0] val,
                                          logic [LEVEL_WIDTH-1:0] lvl,
                                          bpq_out_t res);
        step_row_t row;
        row        = req_row(act, val, lvl);
        row.typed  = 1'b1;
        row.result = res;
        return row;
    endfunction

    function automatic step_row_t cfg_row(logic [LEVEL_WIDTH-1:0] v);
        step_row_t row;
        row         = '0;
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    task automatic check_field(string name, logic [ELEM_WIDTH-1:0] want,
                               logic [ELEM_WIDTH-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic compare_result(bpq_out_t got);
        bpq_out_t want;
        if (pending_results.size() == 0) begin
            $display("%0t ns: result with no request pending, expected none got %h",
                     $time, got);
            mismatch_count++;
        end else begin
            want = pending_results.pop_front();
            check_field("removed_value", want.removed_value, got.removed_value);
            check_field("front_value", want.front_value, got.front_value);
            check_field("front_level", ELEM_WIDTH'(want.front_level),
                        ELEM_WIDTH'(got.front_level));
            check_field("count", ELEM_WIDTH'(want.count), ELEM_WIDTH'(got.count));
            check_field("is_empty", ELEM_WIDTH'(want.is_empty),
                        ELEM_WIDTH'(got.is_empty));
            check_field("status", ELEM_WIDTH'(want.status), ELEM_WIDTH'(got.status));
        end
    endtask

    // hold s_valid low until every result is back; always waits on aclk
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic set_max_level(logic [LEVEL_WIDTH-1:0] v);
        wait_drained();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        max_level_cfg = v;
    endtask

    task automatic send_request(bpq_in_t r, bit typed, bpq_out_t res);
        bpq_out_t predicted;
        int       gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_step(r);
        pending_results.push_back(typed ? res : predicted);
    endtask

    // result side: check on handshake, then choose the next ready value
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                compare_result(m_data);
            end
            if (rx_stall > 0) begin
                rx_stall <= rx_stall - 1;
                m_ready  <= 1'b0;
            end else begin
                rx_stall <= rx_idle_en ? pick_gap() : 0;
                m_ready  <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        bpq_in_t                req;
        logic [LEVEL_WIDTH-1:0] phase_max;
        int                     sel;
        int                     enq_pct;
        int                     deq_pct;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset state, ignored fields, unused code, extremes
        dir_rows.push_back(chk_row(ACT_QUERY, '0, '0, result_of('0, '0, '0, 0, ST_OK)));
        dir_rows.push_back(chk_row(ACT_DEQUEUE, '0, '0, result_of('0, '0, '0, 0, ST_EMPTY)));
        dir_rows.push_back(chk_row(ACT_UNUSED, 32'hDEADBEEF, 4'd9,
                                   result_of('0, '0, '0, 0, ST_OK)));
        dir_rows.push_back(chk_row(ACT_ENQUEUE, '1, 4'd15,
                                   result_of('0, '1, 4'd15, 1, ST_OK)));
        dir_rows.push_back(chk_row(ACT_ENQUEUE, '0, 4'd0,
                                   result_of('0, '0, 4'd0, 2, ST_OK)));
        dir_rows.push_back(req_row(ACT_ENQUEUE, 32'h12345678, 4'd0));
        dir_rows.push_back(req_row(ACT_ENQUEUE, 32'hA5A5A5A5, 4'd7));
        dir_rows.push_back(req_row(ACT_QUERY, 32'h5A5A5A5A, 4'd3));
        dir_rows.push_back(req_row(ACT_DEQUEUE, '1, 4'd15));
        dir_rows.push_back(req_row(ACT_DEQUEUE, '0, 4'd0));
        // lower the maximum below stored levels; those still drain
        dir_rows.push_back(cfg_row(4'd3));
        dir_rows.push_back(req_row(ACT_ENQUEUE, 32'h11111111, 4'd4));
        dir_rows.push_back(req_row(ACT_ENQUEUE, 32'h22222222, 4'd3));
        dir_rows.push_back(req_row(ACT_ENQUEUE, 32'h33333333, 4'd15));
        dir_rows.push_back(req_row(ACT_DEQUEUE, '0, '0));
        dir_rows.push_back(req_row(ACT_DEQUEUE, '0, '0));
        dir_rows.push_back(req_row(ACT_DEQUEUE, '0, '0));
        dir_rows.push_back(req_row(ACT_DEQUEUE, '0, '0));
        dir_rows.push_back(cfg_row(4'd0));
        dir_rows.push_back(chk_row(ACT_ENQUEUE, 32'h0000FFFF, 4'd1,
                                   result_of('0, '0, '0, 0, ST_BAD_LEVEL)));
        dir_rows.push_back(chk_row(ACT_ENQUEUE, 32'hFFFF0000, 4'd0,
                                   result_of('0, 32'hFFFF0000, 4'd0, 1, ST_OK)));
        dir_rows.push_back(chk_row(ACT_ENQUEUE, 32'h1, 4'd15,
                                   result_of('0, 32'hFFFF0000, 4'd0, 1, ST_BAD_LEVEL)));
        dir_rows.push_back(chk_row(ACT_DEQUEUE, '0, '0,
                                   result_of(32'hFFFF0000, '0, '0, 0, ST_OK)));

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                set_max_level(dir_rows[k].cfg_val);
            end else begin
                send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].result);
            end
        end

        // phases cycle through fill, drain and mixed traffic
        for (int p = 0; p < PHASES; p++) begin
            phase_max = (p == 0) ? LEVEL_WIDTH'(MAX_LEVEL) :
                        (p == 1) ? '0 : LEVEL_WIDTH'($urandom_range(0, MAX_LEVEL));
            set_max_level(phase_max);
            tx_idle_en <= (p % 4 == 0) || (p % 4 == 2);
            rx_idle_en <= (p % 4 == 0) || (p % 4 == 1);
            case (p % 3)
                0:       begin enq_pct = 85; deq_pct = 10; end
                1:       begin enq_pct = 10; deq_pct = 85; end
                default: begin enq_pct = 45; deq_pct = 45; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                sel = $urandom_range(0, 99);
                if (sel < enq_pct) begin
                    req.action = ACT_ENQUEUE;
                end else if (sel < enq_pct + deq_pct) begin
                    req.action = ACT_DEQUEUE;
                end else if (sel < 97) begin
                    req.action = ACT_QUERY;
                end else begin
                    req.action = ACT_UNUSED;
                end
                sel = $urandom_range(0, 9);
                req.elem_value = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom;
                if (phase_max < MAX_LEVEL && $urandom_range(0, 9) == 0) begin
                    req.level = LEVEL_WIDTH'($urandom_range(phase_max + 1, MAX_LEVEL));
                end else begin
                    req.level = LEVEL_WIDTH'($urandom_range(0, phase_max));
                end
                send_request(req, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule
